>>> design/pvau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvau_pkg
// Shared constants, codes and controller/datapath interface types for the
// polyphonic voice allocator.
// ----------------------------------------------------------------------------
package pvau_pkg;

  localparam int VoiceCount = 8;
  localparam int VoiceIdxW  = (VoiceCount > 1) ? $clog2(VoiceCount) : 1;
  localparam int NoteW      = 7;
  localparam int VoiceOutW  = 3;
  localparam int MaskOutW   = 8;
  localparam int KindW      = 2;

  // event kinds
  localparam logic OpNoteOn  = 1'b0;
  localparam logic OpNoteOff = 1'b1;

  // choice kinds
  localparam logic [KindW-1:0] KindSame   = 2'd0;
  localparam logic [KindW-1:0] KindIdle   = 2'd1;
  localparam logic [KindW-1:0] KindStolen = 2'd2;
  localparam logic [KindW-1:0] KindOff    = 2'd3;

  typedef struct packed {
    logic load;    // capture request, reset scan state
    logic issue;   // read next voice, advance scan counter
    logic finish;  // commit allocation, load result registers
  } pvau_cmd_t;

  typedef struct packed {
    logic scan_last;  // counter sits on the last voice
  } pvau_status_t;

endpackage

>>> design/polyphonic_voice_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator_unit
// Note-on/note-off voice allocator: reuse same note, else lowest idle voice,
// else round-robin steal. One result per request.
// ----------------------------------------------------------------------------
// sequence: the accepting edge loads the request, the scan reads one note store
// entry per cycle through the single RAM read port, a drain state lets the last
// voice compare, the finish state commits, and done_o is registered from it;
// a new request is accepted in the strobe cycle
// reset: asynchronous, active low; all voices idle and unassigned, steal
// pointer at voice 0; the result strobe cannot be stalled by the receiver
module polyphonic_voice_allocator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation_i,
  input  logic [pvau_pkg::NoteW-1:0]    note_number_i,
  output logic                          done_o,
  output logic [pvau_pkg::VoiceOutW-1:0] voice_index_o,
  output logic [pvau_pkg::KindW-1:0]    choice_kind_o,
  output logic [pvau_pkg::MaskOutW-1:0] released_mask_o,
  output logic [pvau_pkg::MaskOutW-1:0] active_mask_o
);
  import pvau_pkg::*;

  pvau_cmd_t    cmd;
  pvau_status_t status;

  pvau_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .done_o  (done_o),
    .cmd_o   (cmd),
    .status_i(status)
  );

  pvau_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .operation_i    (operation_i),
    .note_number_i  (note_number_i),
    .voice_index_o  (voice_index_o),
    .choice_kind_o  (choice_kind_o),
    .released_mask_o(released_mask_o),
    .active_mask_o  (active_mask_o)
  );

endmodule

>>> design/pvau_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvau_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pvau_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/pvau_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvau_datapath
// Voice state, note store, scan counter, match/idle search and result
// registers of the voice allocator.
// ----------------------------------------------------------------------------
module pvau_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pvau_pkg::pvau_cmd_t           cmd_i,
  output pvau_pkg::pvau_status_t        status_o,
  input  logic                          operation_i,
  input  logic [pvau_pkg::NoteW-1:0]    note_number_i,
  output logic [pvau_pkg::VoiceOutW-1:0] voice_index_o,
  output logic [pvau_pkg::KindW-1:0]    choice_kind_o,
  output logic [pvau_pkg::MaskOutW-1:0] released_mask_o,
  output logic [pvau_pkg::MaskOutW-1:0] active_mask_o
);
  import pvau_pkg::*;

  logic                 op_q;
  logic [NoteW-1:0]     note_q;
  logic [VoiceIdxW-1:0] cnt_q, cnt_d;
  logic                 cmp_vld_q;
  logic [VoiceIdxW-1:0] cmp_idx_q;
  logic                 found_match_q, found_match_d;
  logic                 found_idle_q, found_idle_d;
  logic [VoiceIdxW-1:0] match_idx_q, match_idx_d;
  logic [VoiceIdxW-1:0] idle_idx_q, idle_idx_d;
  logic [VoiceCount-1:0] active_q, active_d;
  logic [VoiceCount-1:0] assigned_q, assigned_d;
  logic [VoiceCount-1:0] rel_q, rel_d;
  logic [VoiceIdxW-1:0] steal_q, steal_d;
  logic [NoteW-1:0]     rdata;
  logic                 match_now;
  logic                 idle_now;
  logic [VoiceIdxW-1:0] chosen;
  logic [KindW-1:0]     kind;
  logic                 ram_we;
  logic [VoiceCount-1:0] active_after;
  logic [VoiceIdxW+VoiceOutW-1:0] voice_ext;
  logic [VoiceCount+MaskOutW-1:0] act_ext;
  logic [VoiceCount+MaskOutW-1:0] rel_ext;
  logic [VoiceOutW-1:0] voice_res_q;
  logic [KindW-1:0]     kind_res_q;
  logic [MaskOutW-1:0]  rel_res_q;
  logic [MaskOutW-1:0]  act_res_q;

  // note store: its read data only counts for assigned voices, so it needs no reset
  pvau_ram #(
    .Width(NoteW),
    .Depth(VoiceCount)
  ) u_note_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(chosen),
    .wdata_i(note_q),
    .raddr_i(cnt_q),
    .rdata_o(rdata)
  );

  assign status_o.scan_last = (cnt_q == VoiceIdxW'(VoiceCount - 1));

  assign match_now = cmp_vld_q && assigned_q[cmp_idx_q] && (rdata == note_q);
  assign idle_now  = cmp_vld_q && !active_q[cmp_idx_q];

  always_comb begin
    if (found_match_q) begin
      chosen = match_idx_q;
      kind   = KindSame;
    end else if (found_idle_q) begin
      chosen = idle_idx_q;
      kind   = KindIdle;
    end else begin
      chosen = steal_q;
      kind   = KindStolen;
    end
  end

  assign ram_we = cmd_i.finish && (op_q == OpNoteOn);

  always_comb begin
    cnt_d         = cnt_q;
    found_match_d = found_match_q;
    found_idle_d  = found_idle_q;
    match_idx_d   = match_idx_q;
    idle_idx_d    = idle_idx_q;
    active_d      = active_q;
    assigned_d    = assigned_q;
    rel_d         = rel_q;
    steal_d       = steal_q;
    active_after  = active_q;
    if (cmd_i.load) begin
      cnt_d         = '0;
      found_match_d = 1'b0;
      found_idle_d  = 1'b0;
      rel_d         = '0;
    end
    if (cmd_i.issue) begin
      cnt_d = cnt_q + 1'b1;
    end
    if (op_q == OpNoteOn) begin
      if (match_now && !found_match_q) begin
        found_match_d = 1'b1;
        match_idx_d   = cmp_idx_q;
      end
      if (idle_now && !found_idle_q) begin
        found_idle_d = 1'b1;
        idle_idx_d   = cmp_idx_q;
      end
    end else if (match_now) begin
      active_d[cmp_idx_q] = 1'b0;
      rel_d[cmp_idx_q]    = 1'b1;
    end
    if (op_q == OpNoteOn) begin
      active_after[chosen] = 1'b1;
    end
    if (ram_we) begin
      active_d[chosen]   = 1'b1;
      assigned_d[chosen] = 1'b1;
      if (!found_match_q && !found_idle_q) begin
        steal_d = (steal_q == VoiceIdxW'(VoiceCount - 1)) ? '0 : steal_q + 1'b1;
      end
    end
  end

  assign voice_ext = {{VoiceOutW{1'b0}}, chosen};
  assign act_ext   = {{MaskOutW{1'b0}}, active_after};
  assign rel_ext   = {{MaskOutW{1'b0}}, rel_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q         <= '0;
      cmp_vld_q     <= 1'b0;
      found_match_q <= 1'b0;
      found_idle_q  <= 1'b0;
      active_q      <= '0;
      assigned_q    <= '0;
      rel_q         <= '0;
      steal_q       <= '0;
    end else begin
      cnt_q         <= cnt_d;
      cmp_vld_q     <= cmd_i.issue;
      found_match_q <= found_match_d;
      found_idle_q  <= found_idle_d;
      active_q      <= active_d;
      assigned_q    <= assigned_d;
      rel_q         <= rel_d;
      steal_q       <= steal_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q   <= cnt_q;
    match_idx_q <= match_idx_d;
    idle_idx_q  <= idle_idx_d;
    if (cmd_i.load) begin
      op_q   <= operation_i;
      note_q <= note_number_i;
    end
    if (cmd_i.finish) begin
      if (op_q == OpNoteOn) begin
        voice_res_q <= voice_ext[VoiceOutW-1:0];
        kind_res_q  <= kind;
        rel_res_q   <= '0;
      end else begin
        voice_res_q <= '0;
        kind_res_q  <= KindOff;
        rel_res_q   <= rel_ext[MaskOutW-1:0];
      end
      act_res_q <= act_ext[MaskOutW-1:0];
    end
  end

  assign voice_index_o   = voice_res_q;
  assign choice_kind_o   = kind_res_q;
  assign released_mask_o = rel_res_q;
  assign active_mask_o   = act_res_q;

endmodule

>>> design/pvau_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvau_ctrl
// Sequencer of the voice allocator: accepts a request, walks the scan,
// commits the allocation and strobes the result.
// ----------------------------------------------------------------------------
module pvau_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  output logic                   done_o,
  output pvau_pkg::pvau_cmd_t    cmd_o,
  input  pvau_pkg::pvau_status_t status_i
);
  import pvau_pkg::*;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StDrain  = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  logic [1:0] state_q, state_d;
  logic       done_q;

  always_comb begin
    state_d      = state_q;
    cmd_o.load   = 1'b0;
    cmd_o.issue  = 1'b0;
    cmd_o.finish = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = StScan;
        end
      end
      StScan: begin
        cmd_o.issue = 1'b1;
        if (status_i.scan_last) begin
          state_d = StDrain;
        end
      end
      // last voice compares here
      StDrain: begin
        state_d = StFinish;
      end
      StFinish: begin
        cmd_o.finish = 1'b1;
        state_d      = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == StFinish);
    end
  end

  assign busy   = (state_q != StIdle);
  assign done_o = done_q;

endmodule

>>> design/pvau_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvau_checker
// Port-level checks of the voice allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pvau_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          operation_i,
  input logic [pvau_pkg::NoteW-1:0]    note_number_i,
  input logic                          done_o,
  input logic [pvau_pkg::VoiceOutW-1:0] voice_index_o,
  input logic [pvau_pkg::KindW-1:0]    choice_kind_o,
  input logic [pvau_pkg::MaskOutW-1:0] released_mask_o,
  input logic [pvau_pkg::MaskOutW-1:0] active_mask_o
);
  import pvau_pkg::*;

  // accepted request keeps the unit busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request accepted but busy not raised");

  // the unit leaves busy only by delivering a result
  a_fell_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result strobe");

  a_off_voice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && choice_kind_o == KindOff |-> voice_index_o == '0)
    else $error("note-off result carries a voice index");

  a_on_norel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && choice_kind_o != KindOff |-> released_mask_o == '0)
    else $error("note-on result carries released voices");

  // released voices cannot still be active
  a_rel_inactive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && choice_kind_o == KindOff |-> (released_mask_o & active_mask_o) == '0)
    else $error("released voice still shown active");

endmodule

bind polyphonic_voice_allocator_unit pvau_checker u_pvau_checker (.*);

>>> tb/voice_alloc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice_alloc_checker
// Watches the request and result ports of the voice allocator, keeps its own
// copy of the voice table, predicts each result and compares it field by field
// with what the block returns. Hands the mismatch count and the number of
// results still due to the testbench top.
// ----------------------------------------------------------------------------
module voice_alloc_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  input  logic                           busy,
  input  logic                           operation_i,
  input  logic [pvau_pkg::NoteW-1:0]     note_number_i,
  input  logic                           done_o,
  input  logic [pvau_pkg::VoiceOutW-1:0] voice_index_o,
  input  logic [pvau_pkg::KindW-1:0]     choice_kind_o,
  input  logic [pvau_pkg::MaskOutW-1:0]  released_mask_o,
  input  logic [pvau_pkg::MaskOutW-1:0]  active_mask_o,
  output int unsigned                    mismatch_count,
  output int unsigned                    pending_count
);
  import pvau_pkg::*;

  typedef struct packed {
    logic [VoiceOutW-1:0] voice;
    logic [KindW-1:0]     kind;
    logic [MaskOutW-1:0]  released;
    logic [MaskOutW-1:0]  active;
  } alloc_result_t;

  // shadow voice table
  logic [NoteW-1:0]      held_note [VoiceCount];
  logic [VoiceCount-1:0] sounding;
  logic [VoiceCount-1:0] claimed;
  int unsigned           steal_ptr;

  alloc_result_t         due_allocs [$];
  alloc_result_t         want;
  int unsigned           bad_count;

  function automatic alloc_result_t predict_allocation(input logic op,
                                                       input logic [NoteW-1:0] note);
    alloc_result_t res;
    int            chosen;
    bit            found;
    res    = '0;
    chosen = 0;
    found  = 1'b0;
    if (op == OpNoteOn) begin
      res.kind = KindSame;
      for (int v = 0; v < VoiceCount && !found; v++) begin
        if (claimed[v] && held_note[v] == note) begin
          chosen = v;
          found  = 1'b1;
        end
      end
      if (!found) begin
        res.kind = KindIdle;
        for (int v = 0; v < VoiceCount && !found; v++) begin
          if (!sounding[v]) begin
            chosen = v;
            found  = 1'b1;
          end
        end
      end
      if (!found) begin
        res.kind  = KindStolen;
        chosen    = steal_ptr;
        steal_ptr = (steal_ptr + 1) % VoiceCount;
      end
      sounding[chosen]  = 1'b1;
      claimed[chosen]   = 1'b1;
      held_note[chosen] = note;
    end else begin
      res.kind = KindOff;
      // already idle voices holding the note still count as released
      for (int v = 0; v < VoiceCount; v++) begin
        if (claimed[v] && held_note[v] == note) begin
          sounding[v] = 1'b0;
          if (v < MaskOutW) res.released[v] = 1'b1;
        end
      end
    end
    res.voice = VoiceOutW'(chosen);
    for (int v = 0; v < VoiceCount && v < MaskOutW; v++) res.active[v] = sounding[v];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < VoiceCount; v++) held_note[v] = '0;
      sounding  = '0;
      claimed   = '0;
      steal_ptr = 0;
      due_allocs.delete();
      bad_count = 0;
      mismatch_count <= 0;
      pending_count  <= 0;
    end else begin
      if (done_o) begin
        if (due_allocs.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t mismatch: result with no request pending (voice %0d kind %0d)",
                     $realtime, voice_index_o, choice_kind_o);
        end else begin
          want = due_allocs.pop_front();
          if (voice_index_o !== want.voice || choice_kind_o !== want.kind ||
              released_mask_o !== want.released || active_mask_o !== want.active) begin
            bad_count++;
            if (bad_count <= 10)
              $display({"%0t mismatch: voice exp %0d got %0d, kind exp %0d got %0d, ",
                        "released exp %02h got %02h, active exp %02h got %02h"},
                       $realtime, want.voice, voice_index_o, want.kind, choice_kind_o,
                       want.released, released_mask_o, want.active, active_mask_o);
          end
        end
      end
      if (start && !busy) due_allocs.push_back(predict_allocation(operation_i, note_number_i));
      mismatch_count <= bad_count;
      pending_count  <= due_allocs.size();
    end
  end

endmodule

>>> tb/polyphonic_voice_allocator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator_unit_tb
// Drives note-on and note-off requests into the voice allocator: a directed
// walk through reuse, idle pick, stealing and note-off corners, then random
// phases of well-formed note traffic with noise and random gaps. A checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module polyphonic_voice_allocator_unit_tb;
  import pvau_pkg::*;

  logic                 clk   = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 op    = OpNoteOn;
  logic [NoteW-1:0]     note  = '0;
  logic                 busy;
  logic                 done;
  logic [VoiceOutW-1:0] voice_index;
  logic [KindW-1:0]     choice_kind;
  logic [MaskOutW-1:0]  released_mask;
  logic [MaskOutW-1:0]  active_mask;
  int unsigned          mismatch_count;
  int unsigned          pending_count;
  bit                   calm;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  polyphonic_voice_allocator_unit DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start           (start),
    .busy            (busy),
    .operation_i     (op),
    .note_number_i   (note),
    .done_o          (done),
    .voice_index_o   (voice_index),
    .choice_kind_o   (choice_kind),
    .released_mask_o (released_mask),
    .active_mask_o   (active_mask)
  );

  voice_alloc_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start           (start),
    .busy            (busy),
    .operation_i     (op),
    .note_number_i   (note),
    .done_o          (done),
    .voice_index_o   (voice_index),
    .choice_kind_o   (choice_kind),
    .released_mask_o (released_mask),
    .active_mask_o   (active_mask),
    .mismatch_count  (mismatch_count),
    .pending_count   (pending_count)
  );

  // present one request and hold it until the block takes it
  task automatic send_note_event(input logic ev_op, input logic [NoteW-1:0] ev_note);
    start <= 1'b1;
    op    <= ev_op;
    note  <= ev_note;
    do @(posedge clk); while (busy);
  endtask

  task automatic maybe_pause();
    if (!calm && $urandom_range(0, 99) < 22) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  initial begin
    logic [NoteW-1:0] sounding_notes [$];
    logic [NoteW-1:0] pick;
    logic             ev_op;
    int unsigned      on_pct;
    int unsigned      base;
    int unsigned      r;
    int               idx;

    on_pct = 60;
    base   = 0;
    calm   = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // note-off before any voice was used must match nothing, not even note 0
    send_note_event(OpNoteOff, 7'd0);    maybe_pause();
    send_note_event(OpNoteOn, 7'd0);     maybe_pause();
    send_note_event(OpNoteOn, 7'd127);   maybe_pause();
    send_note_event(OpNoteOn, 7'd0);     maybe_pause();
    send_note_event(OpNoteOff, 7'd0);    maybe_pause();
    // release of a voice that is already idle
    send_note_event(OpNoteOff, 7'd0);    maybe_pause();
    send_note_event(OpNoteOff, 7'd127);  maybe_pause();
    // released voice with the same note wins over the lower idle voice
    send_note_event(OpNoteOn, 7'd127);   maybe_pause();
    send_note_event(OpNoteOn, 7'd42);    maybe_pause();
    send_note_event(OpNoteOn, 7'd85);    maybe_pause();
    for (int n = 1; n <= 5; n++) begin
      send_note_event(OpNoteOn, NoteW'(n));
      maybe_pause();
    end
    // all voices busy: round-robin stealing
    send_note_event(OpNoteOn, 7'd100);   maybe_pause();
    send_note_event(OpNoteOn, 7'd101);   maybe_pause();
    send_note_event(OpNoteOn, 7'd102);   maybe_pause();
    send_note_event(OpNoteOn, 7'd101);   maybe_pause();
    send_note_event(OpNoteOff, 7'd126);  maybe_pause();
    send_note_event(OpNoteOff, 7'd100);
    drain_results();

    for (int k = 0; k < 1400; k++) begin
      if (k % 200 == 0) begin
        base = $urandom_range(0, 112);
        case ((k / 200) % 3)
          0:       on_pct = 60;
          1:       on_pct = 80;
          default: on_pct = 45;
        endcase
      end
      calm = (k >= 400 && k < 700);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // noise: anything goes
        ev_op = $urandom_range(0, 1) ? OpNoteOff : OpNoteOn;
        pick  = NoteW'($urandom_range(0, 127));
      end else if ($urandom_range(0, 99) < on_pct || sounding_notes.size() == 0) begin
        ev_op = OpNoteOn;
        if ($urandom_range(0, 99) < 80) pick = NoteW'(base + $urandom_range(0, 15));
        else pick = NoteW'($urandom_range(0, 127));
        sounding_notes.push_back(pick);
        if (sounding_notes.size() > 12) void'(sounding_notes.pop_front());
      end else begin
        ev_op = OpNoteOff;
        idx   = $urandom_range(0, sounding_notes.size() - 1);
        pick  = sounding_notes[idx];
        sounding_notes.delete(idx);
      end
      send_note_event(ev_op, pick);
      if (k % 250 == 249 || k == 1399) drain_results();
      else maybe_pause();
    end

    repeat (30) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
